// File: sv/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

    localparam int BLK_W     = 12;
    localparam int WORD_BITS = 64;
    localparam int WORD_LOG  = 6;
    localparam int SCAN_W    = BLK_W - WORD_LOG;

    localparam logic [1:0] CMD_MARK  = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;

    localparam logic [BLK_W-1:0] HIGHEST_RESET = {BLK_W{1'b1}};
    localparam logic [BLK_W-1:0] NONE_FREE     = {BLK_W{1'b1}};

    typedef struct packed {
        logic                 found;
        logic [WORD_LOG-1:0]  pos;
        logic [WORD_BITS-1:0] onehot;
    } find_t;

endpackage

// File: sv/bba_mem.sv
// Bitmap storage: one write port and one read port with registered read data.
module bba_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [bba_pkg::WORD_BITS-1:0]  wr_data,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [bba_pkg::WORD_BITS-1:0]  rd_data
);

    logic [bba_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [bba_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/bba_find.sv
// First clear bit search over one bitmap word, lowest position first.
module bba_find (
    input  logic [bba_pkg::WORD_BITS-1:0] word,
    output bba_pkg::find_t                res
);

    logic [bba_pkg::WORD_BITS-1:0] clear_bits;
    logic [bba_pkg::WORD_BITS-1:0] lowest;
    logic [bba_pkg::WORD_LOG-1:0]  pos;

    // Two's complement trick isolates the lowest clear bit as a one-hot word.
    assign clear_bits = ~word;
    assign lowest     = clear_bits & (~clear_bits + {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1});

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < bba_pkg::WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                pos = pos | bba_pkg::WORD_LOG'(i);
            end
        end
    end

    assign res.found  = |clear_bits;
    assign res.pos    = pos;
    assign res.onehot = lowest;

endmodule

// File: sv/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: sequencer, config register, output register.
//
//   Channel   Signals                            Direction  Meaning
//   cfg       cfg_write, cfg_data                in         highest_block write
//   in        in_valid, in_stall, command,       in         one command per transfer
//             block_index
//   out       out_valid, out_stall, block_number, out       one result per command
//             alloc_failed
//
// Every command, the unused one too, reads its row on the transfer; mark and free update it in
// ST_CHECK, allocate scans rows of 64 blocks in ST_SCAN, at most min(highest_block, NUM_BLOCKS-1)/64 + 1
// of them, one by one through the one bitmap read port; ST_DONE then loads the output register.
// The next transfer can be taken in the cycle after the output register is loaded.
// After reset a clearing pass writes ceil(NUM_BLOCKS/64) rows, one per cycle, with in_stall high.
// A new command is taken while a finished result still waits in the output register.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [bba_pkg::BLK_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 command,
    input  logic [bba_pkg::BLK_W-1:0]  block_index,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [bba_pkg::BLK_W-1:0]  block_number,
    output logic                       alloc_failed
);

    localparam int ROWS  = (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [ROW_W-1:0]              clr_row_reg, clr_row_next;
    logic [bba_pkg::SCAN_W-1:0]    scan_row_reg, scan_row_next;
    logic [bba_pkg::BLK_W-1:0]     highest_reg;
    logic [1:0]                    cmd_reg, cmd_next;
    logic [bba_pkg::BLK_W-1:0]     idx_reg, idx_next;
    logic [bba_pkg::BLK_W-1:0]     res_blk_reg, res_blk_next;
    logic                          res_fail_reg, res_fail_next;
    logic                          out_valid_reg, out_valid_next;
    logic [bba_pkg::BLK_W-1:0]     out_blk_reg, out_blk_next;
    logic                          out_fail_reg, out_fail_next;

    logic                          mem_we;
    logic [ROW_W-1:0]              mem_waddr;
    logic [bba_pkg::WORD_BITS-1:0] mem_wdata;
    logic                          mem_re;
    logic [ROW_W-1:0]              mem_raddr;
    logic [bba_pkg::WORD_BITS-1:0] mem_rdata;

    logic [bba_pkg::BLK_W-1:0]     limit;
    logic [bba_pkg::SCAN_W-1:0]    last_row;
    logic                          scan_last;
    logic [bba_pkg::WORD_BITS-1:0] keep_mask;
    logic [bba_pkg::WORD_BITS-1:0] scan_word;
    bba_pkg::find_t                fres;
    logic [bba_pkg::WORD_BITS-1:0] bit_mask;
    logic                          idx_in_range;
    logic                          accept;
    logic                          out_free;

    bba_mem #(
        .DEPTH (ROWS),
        .AW    (ROW_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    bba_find u_find (
        .word (scan_word),
        .res  (fres)
    );

    // The scan stops at the configured block or the end of the map, whichever is lower.
    assign limit = (32'(highest_reg) > (NUM_BLOCKS - 1)) ? bba_pkg::BLK_W'(NUM_BLOCKS - 1)
                                                         : highest_reg;
    assign last_row  = limit[bba_pkg::BLK_W-1:bba_pkg::WORD_LOG];
    assign scan_last = (scan_row_reg == last_row);
    assign keep_mask = {bba_pkg::WORD_BITS{1'b1}}
                       >> (bba_pkg::WORD_LOG'(bba_pkg::WORD_BITS - 1)
                           - limit[bba_pkg::WORD_LOG-1:0]);
    // Blocks past the limit in the last row look used so the search skips them.
    assign scan_word = scan_last ? (mem_rdata | ~keep_mask) : mem_rdata;

    assign bit_mask     = bba_pkg::WORD_BITS'(1) << idx_reg[bba_pkg::WORD_LOG-1:0];
    assign idx_in_range = (32'(idx_reg) < NUM_BLOCKS);

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        scan_row_next  = scan_row_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        res_blk_next   = res_blk_reg;
        res_fail_next  = res_fail_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_blk_next   = out_blk_reg;
        out_fail_next  = out_fail_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_row_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = ROW_W'(scan_row_reg + 1'b1);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = command;
                    idx_next      = block_index;
                    scan_row_next = '0;
                    mem_re        = 1'b1;
                    if (command == bba_pkg::CMD_ALLOC)
                    begin
                        mem_raddr  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        mem_raddr  = ROW_W'(block_index[bba_pkg::BLK_W-1:bba_pkg::WORD_LOG]);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                mem_waddr = ROW_W'(idx_reg[bba_pkg::BLK_W-1:bba_pkg::WORD_LOG]);
                if (cmd_reg == bba_pkg::CMD_MARK)
                begin
                    mem_wdata = mem_rdata | bit_mask;
                    mem_we    = idx_in_range;
                end
                else
                begin
                    mem_wdata = mem_rdata & ~bit_mask;
                    // Block zero is never freed.
                    mem_we    = (cmd_reg == bba_pkg::CMD_FREE) && idx_in_range
                                && (idx_reg != '0);
                end
                res_blk_next  = idx_reg;
                res_fail_next = 1'b0;
                state_next    = ST_DONE;
            end
            ST_SCAN:
            begin
                mem_waddr = ROW_W'(scan_row_reg);
                mem_wdata = mem_rdata | fres.onehot;
                if (fres.found)
                begin
                    mem_we        = 1'b1;
                    res_blk_next  = {scan_row_reg, fres.pos};
                    res_fail_next = 1'b0;
                    state_next    = ST_DONE;
                end
                else if (scan_last)
                begin
                    res_blk_next  = bba_pkg::NONE_FREE;
                    res_fail_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    mem_re        = 1'b1;
                    scan_row_next = scan_row_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_blk_next   = res_blk_reg;
                    out_fail_next  = res_fail_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            scan_row_reg  <= '0;
            out_valid_reg <= 1'b0;
            highest_reg   <= bba_pkg::HIGHEST_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            scan_row_reg  <= scan_row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                highest_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        res_blk_reg  <= res_blk_next;
        res_fail_reg <= res_fail_next;
        out_blk_reg  <= out_blk_next;
        out_fail_reg <= out_fail_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign block_number = out_blk_reg;
    assign alloc_failed = out_fail_reg;

    // A failed allocation always carries the all-ones block number.
    a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alloc_failed |-> block_number == bba_pkg::NONE_FREE)
        else $error("failed allocation without all-ones block number");

    // A block handed out never lies past the scan limit.
    a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && fres.found |-> {scan_row_reg, fres.pos} <= limit)
        else $error("allocated block beyond limit");

    // The scan advances exactly one row per cycle.
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && $past(state_reg) == ST_SCAN
        |-> scan_row_reg == $past(scan_row_reg) + 6'd1)
        else $error("scan skipped or repeated a row");

    // Mark and free touch at most one bit of the row.
    a_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK && mem_we |-> $countones(mem_wdata ^ mem_rdata) <= 1)
        else $error("mark or free changed more than one bit");

endmodule
